// ----- design/ehpp_pkg.sv -----
`default_nettype none

package ehpp_pkg;

    // framing
    localparam logic [7:0] SYNC_BYTE = 8'hAA;

    // payload row codes
    localparam logic [7:0] CODE_QUALITY    = 8'h02;
    localparam logic [7:0] CODE_ATTENTION  = 8'h04;
    localparam logic [7:0] CODE_MEDITATION = 8'h05;
    localparam logic [7:0] CODE_BANDS      = 8'h83;
    localparam logic [7:0] CODE_RAW        = 8'h80;

    // result status codes
    typedef logic [1:0] status_t;
    localparam status_t STATUS_GOOD     = 2'd0;
    localparam status_t STATUS_CHECKSUM = 2'd1;
    localparam status_t STATUS_PARSE    = 2'd2;
    localparam status_t STATUS_LENGTH   = 2'd3;

    // reset values
    localparam logic [7:0] QUALITY_RESET = 8'd200;
    localparam logic [7:0] CUTOFF_RESET  = 8'd55;

endpackage

`default_nettype wire

// ----- design/eeg_headset_packet_parser_unit.sv -----
`default_nettype none

// Packet parser for a headset serial link. Bytes arrive one per transaction on
// the s_axis side; the parser hunts for two 0xAA sync bytes, takes a length
// byte (a length above MAX_PAYLOAD gives a single status 3 result and drops
// the packet), stores the payload in a synchronous memory with one write and
// one read port while keeping an 8-bit sum, and compares the checksum byte
// with the inverted sum. A mismatch gives one status 1 result. On a match the
// stored payload is walked row by row: 0x02, 0x04, 0x05 load quality,
// attention and meditation, 0x83 loads BAND_COUNT 24-bit big-endian band
// powers into a small band memory, 0x80 skips three bytes, anything else (or a
// row running past the payload end) marks a parse failure, reported as one
// status 2 result. A good packet gives BAND_COUNT results, one per band, tlast
// on the final one, and attention is zeroed first when quality is at or above
// the quality_cutoff register. Sync, length and payload bytes are taken only
// in the input state while the output register is empty or is being emptied
// in the same cycle. The checksum byte starts the walk, which steps over each
// payload byte with a memory read then a decode, then takes a finishing step,
// then gives each band result with a band memory read then an output load;
// no input byte is taken until the walk and its results are done.
// The payload memory has no clearing pass; only entries written by the
// current packet are read. The quality_cutoff register is written over the
// cfg channel, which is always ready.
module eeg_headset_packet_parser_unit #(
    parameter int MAX_PAYLOAD = 32,
    parameter int BAND_COUNT  = 8
) (
    input  wire         clk,
    input  wire         rst_n,

    // configuration write: quality_cutoff
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [7:0]  cfg_data,

    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] data_byte

    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [7:0] quality, [15:8] attention_level,
                                        // [23:16] meditation_level, [47:24] band_power
    output logic [4:0]  m_axis_tuser,   // [1:0] status, [4:2] band_index
    output logic        m_axis_tlast    // last
);
    import ehpp_pkg::*;

    localparam int ADDR_W = $clog2(MAX_PAYLOAD);
    localparam int PTR_W  = $clog2(MAX_PAYLOAD + 3 * BAND_COUNT + 3);
    localparam int BAND_W = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
    localparam logic [7:0]        MAX_LEN   = 8'(MAX_PAYLOAD);
    localparam logic [BAND_W-1:0] BAND_LAST = BAND_W'(BAND_COUNT - 1);

    // control states
    localparam logic [2:0] S_IN   = 3'd0;  // taking serial bytes
    localparam logic [2:0] S_RD   = 3'd1;  // payload read issued
    localparam logic [2:0] S_USE  = 3'd2;  // payload byte decoded
    localparam logic [2:0] S_FIN  = 3'd3;  // walk finished
    localparam logic [2:0] S_BRD  = 3'd4;  // band read issued
    localparam logic [2:0] S_BOUT = 3'd5;  // band result out

    // what the next payload byte means
    localparam logic [2:0] K_CODE = 3'd0;
    localparam logic [2:0] K_QUAL = 3'd1;
    localparam logic [2:0] K_ATT  = 3'd2;
    localparam logic [2:0] K_MED  = 3'd3;
    localparam logic [2:0] K_SKIP = 3'd4;
    localparam logic [2:0] K_BAND = 3'd5;
    localparam logic [2:0] K_IGN  = 3'd6;

    // memories
    logic [7:0]  pay_mem  [MAX_PAYLOAD];
    logic [23:0] band_mem [BAND_COUNT];
    logic [7:0]  pay_rd_reg;
    logic [23:0] band_rd_reg;

    // registers
    logic [2:0]            state_reg, state_next;
    logic [7:0]            cutoff_reg, cutoff_next;
    logic [7:0]            prev_reg, prev_next;
    logic                  inside_reg, inside_next;
    logic [7:0]            pos_reg, pos_next;
    logic [7:0]            len_reg, len_next;
    logic [7:0]            sum_reg, sum_next;
    logic [7:0]            qual_reg, qual_next;
    logic [7:0]            att_reg, att_next;
    logic [7:0]            med_reg, med_next;
    logic [PTR_W-1:0]      ptr_reg, ptr_next;
    logic [2:0]            kind_reg, kind_next;
    logic [1:0]            sub_reg, sub_next;
    logic [BAND_W-1:0]     band_reg, band_next;
    logic [15:0]           acc_reg, acc_next;
    logic                  ok_reg, ok_next;
    logic                  rng_reg, rng_next;
    logic [BAND_COUNT-1:0] bvld_reg, bvld_next;
    logic                  ovld_reg, ovld_next;
    status_t               ostat_reg, ostat_next;
    logic [7:0]            oqual_reg, oqual_next;
    logic [7:0]            oatt_reg, oatt_next;
    logic [7:0]            omed_reg, omed_next;
    logic [BAND_W-1:0]     oband_reg, oband_next;
    logic [23:0]           opow_reg, opow_next;
    logic                  olast_reg, olast_next;

    // memory ports
    logic              pay_we, pay_re, band_we, band_re;
    logic [ADDR_W-1:0] pay_waddr, pay_raddr;
    logic [23:0]       band_wdata;

    logic              slot_free;
    logic              in_acc;
    logic [7:0]        in_byte;
    logic [PTR_W-1:0]  len_ptr;

    assign slot_free     = !ovld_reg || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_byte       = s_axis_tdata;
    assign len_ptr       = PTR_W'(len_reg);
    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == S_IN) && slot_free;

    assign m_axis_tvalid = ovld_reg;
    assign m_axis_tdata  = {opow_reg, omed_reg, oatt_reg, oqual_reg};
    assign m_axis_tuser  = {3'(oband_reg), ostat_reg};
    assign m_axis_tlast  = olast_reg;

    always_comb
    begin
        logic [7:0]       d;
        logic [PTR_W-1:0] ptr_inc;
        logic             inside_after;

        state_next  = state_reg;
        cutoff_next = cutoff_reg;
        prev_next   = prev_reg;
        inside_next = inside_reg;
        pos_next    = pos_reg;
        len_next    = len_reg;
        sum_next    = sum_reg;
        qual_next   = qual_reg;
        att_next    = att_reg;
        med_next    = med_reg;
        ptr_next    = ptr_reg;
        kind_next   = kind_reg;
        sub_next    = sub_reg;
        band_next   = band_reg;
        acc_next    = acc_reg;
        ok_next     = ok_reg;
        rng_next    = rng_reg;
        bvld_next   = bvld_reg;
        ovld_next   = ovld_reg && !m_axis_tready;
        ostat_next  = ostat_reg;
        oqual_next  = oqual_reg;
        oatt_next   = oatt_reg;
        omed_next   = omed_reg;
        oband_next  = oband_reg;
        opow_next   = opow_reg;
        olast_next  = olast_reg;

        pay_we     = 1'b0;
        pay_re     = 1'b0;
        band_we    = 1'b0;
        band_re    = 1'b0;
        pay_waddr  = ADDR_W'(pos_reg - 8'd1);
        pay_raddr  = ADDR_W'(ptr_reg);
        band_wdata = {acc_reg, 8'd0};

        d            = rng_reg ? pay_rd_reg : 8'd0;
        ptr_inc      = ptr_reg + PTR_W'(1);
        inside_after = inside_reg;

        if (cfg_valid)
        begin
            cutoff_next = cfg_data;
        end

        case (state_reg)
            S_IN:
            begin
                if (in_acc)
                begin
                    if (inside_reg)
                    begin
                        if (pos_reg == 8'd0)
                        begin
                            len_next = in_byte;
                            if (in_byte > MAX_LEN)
                            begin
                                // length too long: drop the packet
                                inside_after = 1'b0;
                                ovld_next    = 1'b1;
                                ostat_next   = STATUS_LENGTH;
                                oqual_next   = qual_reg;
                                oatt_next    = att_reg;
                                omed_next    = med_reg;
                                oband_next   = '0;
                                opow_next    = 24'd0;
                                olast_next   = 1'b1;
                            end
                        end
                        else if (pos_reg <= len_reg)
                        begin
                            pay_we   = 1'b1;
                            sum_next = sum_reg + in_byte;
                        end
                        else
                        begin
                            inside_after = 1'b0;
                            if (in_byte != ~sum_reg)
                            begin
                                ovld_next  = 1'b1;
                                ostat_next = STATUS_CHECKSUM;
                                oqual_next = qual_reg;
                                oatt_next  = att_reg;
                                omed_next  = med_reg;
                                oband_next = '0;
                                opow_next  = 24'd0;
                                olast_next = 1'b1;
                            end
                            else
                            begin
                                // checksum good: start the payload walk
                                ptr_next   = '0;
                                kind_next  = K_CODE;
                                ok_next    = 1'b1;
                                bvld_next  = '0;
                                state_next = (len_reg == 8'd0) ? S_FIN : S_RD;
                            end
                        end
                        pos_next = pos_reg + 8'd1;
                    end
                    inside_next = inside_after;
                    if (in_byte == SYNC_BYTE && prev_reg == SYNC_BYTE && !inside_after)
                    begin
                        inside_next = 1'b1;
                        pos_next    = 8'd0;
                        sum_next    = 8'd0;
                    end
                    prev_next = in_byte;
                end
            end

            S_RD:
            begin
                rng_next   = ptr_reg < len_ptr;
                pay_re     = ptr_reg < len_ptr;
                state_next = S_USE;
            end

            S_USE:
            begin
                if (!rng_reg && kind_reg != K_SKIP)
                begin
                    ok_next = 1'b0;
                end
                ptr_next = ptr_inc;
                case (kind_reg)
                    K_CODE:
                    begin
                        case (d)
                            CODE_QUALITY:    kind_next = K_QUAL;
                            CODE_ATTENTION:  kind_next = K_ATT;
                            CODE_MEDITATION: kind_next = K_MED;
                            CODE_BANDS:      kind_next = K_SKIP;
                            CODE_RAW:
                            begin
                                kind_next = K_IGN;
                                sub_next  = 2'd0;
                            end
                            default:
                            begin
                                ok_next   = 1'b0;
                                kind_next = K_CODE;
                            end
                        endcase
                    end
                    K_QUAL:
                    begin
                        qual_next = d;
                        kind_next = K_CODE;
                    end
                    K_ATT:
                    begin
                        att_next  = d;
                        kind_next = K_CODE;
                    end
                    K_MED:
                    begin
                        med_next  = d;
                        kind_next = K_CODE;
                    end
                    K_SKIP:
                    begin
                        kind_next = K_BAND;
                        band_next = '0;
                        sub_next  = 2'd0;
                    end
                    K_BAND:
                    begin
                        // big-endian triple, shifted in high byte first
                        acc_next = {acc_reg[7:0], d};
                        if (sub_reg == 2'd2)
                        begin
                            band_we    = 1'b1;
                            band_wdata = {acc_reg, d};
                            bvld_next[band_reg] = 1'b1;
                            sub_next   = 2'd0;
                            if (band_reg == BAND_LAST)
                            begin
                                kind_next = K_CODE;
                            end
                            else
                            begin
                                band_next = band_reg + BAND_W'(1);
                            end
                        end
                        else
                        begin
                            sub_next = sub_reg + 2'd1;
                        end
                    end
                    K_IGN:
                    begin
                        if (sub_reg == 2'd2)
                        begin
                            kind_next = K_CODE;
                        end
                        else
                        begin
                            sub_next = sub_reg + 2'd1;
                        end
                    end
                    default:
                    begin
                        kind_next = K_CODE;
                    end
                endcase
                // rows only start below the payload end
                if (kind_next == K_CODE && !(ptr_inc < len_ptr))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_RD;
                end
            end

            S_FIN:
            begin
                if (ok_reg)
                begin
                    if (qual_reg >= cutoff_reg)
                    begin
                        att_next = 8'd0;
                    end
                    band_next  = '0;
                    state_next = S_BRD;
                end
                else if (slot_free)
                begin
                    ovld_next  = 1'b1;
                    ostat_next = STATUS_PARSE;
                    oqual_next = qual_reg;
                    oatt_next  = att_reg;
                    omed_next  = med_reg;
                    oband_next = '0;
                    opow_next  = 24'd0;
                    olast_next = 1'b1;
                    state_next = S_IN;
                end
            end

            S_BRD:
            begin
                band_re    = 1'b1;
                state_next = S_BOUT;
            end

            S_BOUT:
            begin
                if (slot_free)
                begin
                    ovld_next  = 1'b1;
                    ostat_next = STATUS_GOOD;
                    oqual_next = qual_reg;
                    oatt_next  = att_reg;
                    omed_next  = med_reg;
                    oband_next = band_reg;
                    opow_next  = bvld_reg[band_reg] ? band_rd_reg : 24'd0;
                    olast_next = (band_reg == BAND_LAST);
                    if (band_reg == BAND_LAST)
                    begin
                        state_next = S_IN;
                    end
                    else
                    begin
                        band_next  = band_reg + BAND_W'(1);
                        state_next = S_BRD;
                    end
                end
            end

            default:
            begin
                state_next = S_IN;
            end
        endcase
    end

    // payload memory: one write port from the byte stream, one read port for the walk
    always_ff @(posedge clk)
    begin
        if (pay_we)
        begin
            pay_mem[pay_waddr] <= in_byte;
        end
        if (pay_re)
        begin
            pay_rd_reg <= pay_mem[pay_raddr];
        end
    end

    // band power memory, entries not loaded this walk read as zero via bvld_reg
    always_ff @(posedge clk)
    begin
        if (band_we)
        begin
            band_mem[band_reg] <= band_wdata;
        end
        if (band_re)
        begin
            band_rd_reg <= band_mem[band_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IN;
            cutoff_reg <= CUTOFF_RESET;
            prev_reg   <= 8'd0;
            inside_reg <= 1'b0;
            pos_reg    <= 8'd0;
            len_reg    <= 8'd0;
            sum_reg    <= 8'd0;
            qual_reg   <= QUALITY_RESET;
            att_reg    <= 8'd0;
            med_reg    <= 8'd0;
            ptr_reg    <= '0;
            kind_reg   <= K_CODE;
            sub_reg    <= 2'd0;
            band_reg   <= '0;
            acc_reg    <= 16'd0;
            ok_reg     <= 1'b0;
            rng_reg    <= 1'b0;
            bvld_reg   <= '0;
            ovld_reg   <= 1'b0;
            ostat_reg  <= STATUS_GOOD;
            oqual_reg  <= 8'd0;
            oatt_reg   <= 8'd0;
            omed_reg   <= 8'd0;
            oband_reg  <= '0;
            opow_reg   <= 24'd0;
            olast_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cutoff_reg <= cutoff_next;
            prev_reg   <= prev_next;
            inside_reg <= inside_next;
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            sum_reg    <= sum_next;
            qual_reg   <= qual_next;
            att_reg    <= att_next;
            med_reg    <= med_next;
            ptr_reg    <= ptr_next;
            kind_reg   <= kind_next;
            sub_reg    <= sub_next;
            band_reg   <= band_next;
            acc_reg    <= acc_next;
            ok_reg     <= ok_next;
            rng_reg    <= rng_next;
            bvld_reg   <= bvld_next;
            ovld_reg   <= ovld_next;
            ostat_reg  <= ostat_next;
            oqual_reg  <= oqual_next;
            oatt_reg   <= oatt_next;
            omed_reg   <= omed_next;
            oband_reg  <= oband_next;
            opow_reg   <= opow_next;
            olast_reg  <= olast_next;
        end
    end

endmodule

`default_nettype wire
